// File: rtl/s256_pkg.sv
package s256_pkg;

   typedef logic [31:0] s256_word_type;
   typedef logic [7:0][31:0] s256_hash_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_LEN,
      ST_ROUND,
      ST_UPDATE,
      ST_EMIT
   } s256_state_type;

   // Control from the sequencer to the round unit
   typedef struct packed {
      logic          push_word;
      s256_word_type word;
      logic          load_vars;
      logic          run_round;
      logic [5:0]    round_idx;
   } s256_ctl_type;

   localparam logic CMD_ABSORB = 1'b0;
   localparam logic CMD_FINISH = 1'b1;

   localparam logic [7:0] PAD_BYTE = 8'h80;
   localparam logic [5:0] LEN_FILL = 6'd56;
   localparam logic [5:0] LAST_FILL = 6'd63;
   localparam logic [5:0] LAST_ROUND = 6'd63;
   localparam logic [2:0] LAST_WORD = 3'd7;

   // Initial chaining value, H0 at index 0
   localparam s256_hash_type INIT_HASH = {
      32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
      32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
   };

   localparam s256_word_type ROUND_K [0:63] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

endpackage

// File: rtl/s256_round_unit.sv
module s256_round_unit (
   input  logic                  clock,
   input  s256_pkg::s256_ctl_type ctl,
   input  s256_pkg::s256_hash_type chain_init,
   output s256_pkg::s256_hash_type vars
);
   import s256_pkg::*;

   function automatic s256_word_type big_sig0(input s256_word_type x);
      return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic s256_word_type big_sig1(input s256_word_type x);
      return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   function automatic s256_word_type small_sig0(input s256_word_type x);
      return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
   endfunction

   function automatic s256_word_type small_sig1(input s256_word_type x);
      return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
   endfunction

   // Schedule window: w_ff[0] is the word for the current round
   s256_word_type w_ff [0:15];
   s256_hash_type v_ff;
   s256_hash_type v_in;
   s256_word_type w_new;
   s256_word_type x1;
   s256_word_type x2;
   s256_word_type chs;
   s256_word_type maj;

   // Extend the schedule by one word
   assign w_new = w_ff[0] + small_sig0(w_ff[1]) + w_ff[9] + small_sig1(w_ff[14]);

   // One compression round
   always_comb begin
      chs = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
      maj = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
      x1 = v_ff[7] + big_sig1(v_ff[4]) + chs + ROUND_K[ctl.round_idx] + w_ff[0];
      x2 = big_sig0(v_ff[0]) + maj;
      v_in[7] = v_ff[6];
      v_in[6] = v_ff[5];
      v_in[5] = v_ff[4];
      v_in[4] = v_ff[3] + x1;
      v_in[3] = v_ff[2];
      v_in[2] = v_ff[1];
      v_in[1] = v_ff[0];
      v_in[0] = x1 + x2;
   end

   // Shift the window on a loaded word or on a round
   always_ff @(posedge clock) begin
      if (ctl.push_word || ctl.run_round) begin
         for (int i = 0; i < 15; i++) begin
            w_ff[i] <= w_ff[i+1];
         end
         w_ff[15] <= ctl.push_word ? ctl.word : w_new;
      end
   end

   // Load working variables, then advance them one round per cycle
   always_ff @(posedge clock) begin
      if (ctl.load_vars) begin
         v_ff <= chain_init;
      end else if (ctl.run_round) begin
         v_ff <= v_in;
      end
   end

   assign vars = v_ff;

endmodule

// File: rtl/sha256_message_hasher.sv
// Absorb beat: taken while idle; every 64th byte then runs a block
// (64 rounds on the shared round unit, then a fold into the chaining value).
// Finish beat: padding and length go in at one byte per cycle up to the block end,
// each filled block runs the same way, then eight digest beats follow, one per
// cycle while rsp_tready is high. No request is taken while a block runs.
// Reset (synchronous, active high) loads the initial hash and clears all counts.
module sha256_message_hasher (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] digest_word
   output logic [2:0]  rsp_tuser,   // [2:0] word_index
   output logic        rsp_tlast
);
   import s256_pkg::*;

   s256_state_type state_ff, state_in;
   s256_state_type ret_ff, ret_in;
   logic [5:0]     fill_ff, fill_in;
   logic [60:0]    msg_ff, msg_in;
   logic [23:0]    acc_ff, acc_in;
   logic [5:0]     rnd_ff, rnd_in;
   logic [2:0]     emit_ff, emit_in;
   logic           first_ff, first_in;
   s256_hash_type  chain_ff, chain_in;

   s256_ctl_type   ctl;
   s256_hash_type  vars;
   logic           req_acc;
   logic           rsp_acc;
   logic           push_en;
   logic [7:0]     push_byte;
   logic           count_msg;
   logic           wrap;
   logic [5:0]     fill_next;
   logic [63:0]    len_bits;
   logic [2:0]     len_sel;

   assign req_acc   = req_tvalid && req_tready;
   assign rsp_acc   = rsp_tvalid && rsp_tready;
   assign fill_next = fill_ff + 6'd1;
   assign wrap      = push_en && (fill_ff == LAST_FILL);
   assign len_bits  = {msg_ff, 3'b000};
   assign len_sel   = LAST_WORD - fill_ff[2:0];

   // Next state
   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (req_tuser == CMD_FINISH) begin
                  state_in = ST_PAD;
               end else if (wrap) begin
                  state_in = ST_ROUND;
                  ret_in   = ST_IDLE;
               end
            end
         end
         ST_PAD: begin
            if (wrap) begin
               state_in = ST_ROUND;
               ret_in   = ST_PAD;
            end else if (fill_next == LEN_FILL) begin
               state_in = ST_LEN;
            end
         end
         ST_LEN: begin
            if (wrap) begin
               state_in = ST_ROUND;
               ret_in   = ST_EMIT;
            end
         end
         ST_ROUND: begin
            if (rnd_ff == LAST_ROUND) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            state_in = ret_ff;
         end
         ST_EMIT: begin
            if (rsp_acc && (emit_ff == LAST_WORD)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs and byte source
   always_comb begin
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      push_en    = 1'b0;
      push_byte  = '0;
      count_msg  = 1'b0;
      ctl        = '0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid && (req_tuser == CMD_ABSORB)) begin
               push_en   = 1'b1;
               push_byte = req_tdata;
               count_msg = 1'b1;
            end
         end
         ST_PAD: begin
            push_en   = 1'b1;
            push_byte = first_ff ? PAD_BYTE : 8'h00;
         end
         ST_LEN: begin
            push_en   = 1'b1;
            push_byte = len_bits[{len_sel, 3'b000} +: 8];
         end
         ST_ROUND: begin
            ctl.run_round = 1'b1;
         end
         ST_EMIT: begin
            rsp_tvalid = 1'b1;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
      ctl.push_word = push_en && (fill_ff[1:0] == 2'b11);
      ctl.word      = {acc_ff, push_byte};
      ctl.load_vars = wrap;
      ctl.round_idx = rnd_ff;
   end

   // Datapath next values
   always_comb begin
      fill_in  = push_en ? fill_next : fill_ff;
      acc_in   = push_en ? {acc_ff[15:0], push_byte} : acc_ff;
      msg_in   = count_msg ? msg_ff + 61'd1 : msg_ff;
      rnd_in   = (state_ff == ST_ROUND) ? rnd_ff + 6'd1 : rnd_ff;
      emit_in  = rsp_acc ? emit_ff + 3'd1 : emit_ff;
      first_in = first_ff;
      chain_in = chain_ff;
      if (state_ff == ST_IDLE && req_acc && (req_tuser == CMD_FINISH)) begin
         first_in = 1'b1;
      end else if (state_ff == ST_PAD) begin
         first_in = 1'b0;
      end
      // Fold the block into the chaining value
      if (state_ff == ST_UPDATE) begin
         for (int i = 0; i < 8; i++) begin
            chain_in[i] = chain_ff[i] + vars[i];
         end
      end
      // Restore the initial state after the last digest beat
      if (rsp_acc && (emit_ff == LAST_WORD)) begin
         chain_in = INIT_HASH;
         msg_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ret_ff   <= ST_IDLE;
         fill_ff  <= '0;
         msg_ff   <= '0;
         rnd_ff   <= '0;
         emit_ff  <= '0;
         first_ff <= 1'b0;
         chain_ff <= INIT_HASH;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         fill_ff  <= fill_in;
         msg_ff   <= msg_in;
         rnd_ff   <= rnd_in;
         emit_ff  <= emit_in;
         first_ff <= first_in;
         chain_ff <= chain_in;
      end
   end

   // Partial word collector
   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   s256_round_unit u_round (
      .clock      (clock),
      .ctl        (ctl),
      .chain_init (chain_ff),
      .vars       (vars)
   );

   assign rsp_tdata = chain_ff[emit_ff];
   assign rsp_tuser = emit_ff;
   assign rsp_tlast = (emit_ff == LAST_WORD);

   // Digest beats only follow a block that ended exactly on the boundary
   a_emit_aligned: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (fill_ff == 6'd0))
      else $error("digest emitted with bytes pending");

   // Length bytes fill only the tail of a block
   a_len_tail: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LEN) |-> (fill_ff[5:3] == 3'b111))
      else $error("length bytes outside block tail");

   // Fold happens only after the full round count
   a_update_after_rounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPDATE) |-> ($past(rnd_ff) == LAST_ROUND))
      else $error("chain fold before all rounds");

   // Never take input while digest beats are pending
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input and output active together");

endmodule

// File: dv/sha256_message_hasher_tb.sv
`timescale 1ns / 100ps

module sha256_message_hasher_tb;
   import s256_pkg::*;

   // One digest word as the block should present it
   typedef struct {
      logic [31:0] word;
      logic [2:0]  index;
      logic        last;
   } digest_beat_type;

   // Tracks the running hash of the byte stream and holds the digest words owed
   class hash_scoreboard;
      logic [31:0]     chain [8];
      logic [7:0]      block_bytes [64];
      int unsigned     fill;
      logic [60:0]     byte_count;
      digest_beat_type digest_fifo [$];
      int              errors;

      const logic [31:0] start_hash [8] = '{
         32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
         32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
      };

      const logic [31:0] round_const [64] = '{
         32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
         32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
         32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
         32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
         32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
         32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
         32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
         32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
         32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
         32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
         32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
         32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
         32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
         32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
         32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
         32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
      };

      function new();
         errors = 0;
         restart();
         foreach (block_bytes[i]) block_bytes[i] = 8'h00;
      endfunction

      // Back to the start of a message
      function void restart();
         foreach (chain[i]) chain[i] = start_hash[i];
         fill = 0;
         byte_count = '0;
      endfunction

      function logic [31:0] rotr(logic [31:0] x, int n);
         return (x >> n) | (x << (32 - n));
      endfunction

      // Fold the 64 buffered bytes into the chaining value
      function void compress_block();
         logic [31:0] w [64];
         logic [31:0] v [8];
         logic [31:0] s0, s1, t1, t2, ch, mj;
         for (int t = 0; t < 16; t++)
            w[t] = {block_bytes[4*t], block_bytes[4*t+1],
                    block_bytes[4*t+2], block_bytes[4*t+3]};
         for (int t = 16; t < 64; t++) begin
            s0 = rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3);
            s1 = rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10);
            w[t] = w[t-16] + s0 + w[t-7] + s1;
         end
         foreach (v[i]) v[i] = chain[i];
         for (int t = 0; t < 64; t++) begin
            s1 = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
            ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
            t1 = v[7] + s1 + ch + round_const[t] + w[t];
            s0 = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
            mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
            t2 = s0 + mj;
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0];
            v[0] = t1 + t2;
         end
         foreach (chain[i]) chain[i] = chain[i] + v[i];
      endfunction

      // Update the hash state for one accepted beat; a finish queues the digest
      function void note_request(logic cmd, logic [7:0] data);
         logic [63:0]     bit_len;
         digest_beat_type beat;
         if (cmd == CMD_ABSORB) begin
            block_bytes[fill] = data;
            byte_count = byte_count + 61'd1;
            fill++;
            if (fill == 64) begin
               compress_block();
               fill = 0;
            end
         end else begin
            for (int i = fill; i < 64; i++) block_bytes[i] = 8'h00;
            block_bytes[fill] = 8'h80;
            // Long tail: no room for the length, spill into a second block
            if (fill >= 56) begin
               compress_block();
               foreach (block_bytes[i]) block_bytes[i] = 8'h00;
            end
            bit_len = {byte_count, 3'b000};
            for (int k = 0; k < 8; k++) block_bytes[56+k] = bit_len[63-8*k -: 8];
            compress_block();
            for (int k = 0; k < 8; k++) begin
               beat.word = chain[k];
               beat.index = 3'(k);
               beat.last = (k == 7);
               digest_fifo.push_back(beat);
            end
            restart();
         end
      endfunction

      // Compare one accepted digest beat with the oldest owed word
      function void check_word(logic [31:0] word, logic [2:0] index, logic last);
         digest_beat_type exp_beat;
         if (digest_fifo.size() == 0) begin
            $display("%0t: unexpected digest beat, expected none, actual %h/%0d/%0b",
                     $time, word, index, last);
            errors++;
            return;
         end
         exp_beat = digest_fifo.pop_front();
         if (word !== exp_beat.word) begin
            $display("%0t: digest_word mismatch, expected %h, actual %h",
                     $time, exp_beat.word, word);
            errors++;
         end
         if (index !== exp_beat.index) begin
            $display("%0t: word_index mismatch, expected %0d, actual %0d",
                     $time, exp_beat.index, index);
            errors++;
         end
         if (last !== exp_beat.last) begin
            $display("%0t: last_word mismatch, expected %0b, actual %0b",
                     $time, exp_beat.last, last);
            errors++;
         end
      endfunction

      function int pending();
         return digest_fifo.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;    // [7:0] data_byte
   logic        req_tuser;    // [0] cmd
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;    // [31:0] digest_word
   logic [2:0]  rsp_tuser;    // [2:0] word_index
   logic        rsp_tlast;

   hash_scoreboard sb = new();
   int             beats_sent = 0;
   bit             quiet = 1'b0;

   sha256_message_hasher u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Hard stop in case the block hangs
   initial begin
      #20000000;
      $display("simulation failed");
      $finish;
   end

   // Send one beat, starting and returning at a falling edge
   task automatic send_beat(input logic cmd, input logic [7:0] data);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(cmd, data);
      beats_sent++;
      @(negedge clock);
   endtask

   // Absorb len random bytes, then close the message
   task automatic send_message(input int len);
      for (int i = 0; i < len; i++) send_beat(CMD_ABSORB, 8'($urandom_range(0, 255)));
      send_beat(CMD_FINISH, 8'($urandom_range(0, 255)));
   endtask

   // Pick a message length, leaning on the padding boundaries
   function automatic int pick_length();
      int sel;
      int len;
      int room;
      int edges [8] = '{55, 56, 57, 63, 64, 65, 119, 120};
      sel = $urandom_range(0, 9);
      if (sel < 5) len = $urandom_range(0, 20);
      else if (sel < 8) len = edges[$urandom_range(0, 7)];
      else len = $urandom_range(0, 130);
      // Keep the run close to its planned beat count
      room = 429 - beats_sent;
      if (room < 0) room = 0;
      return (len > room) ? room : len;
   endfunction

   // Result side: stall in random bursts, none in the closing stretch
   initial begin
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         if (!quiet && $urandom_range(0, 2) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 20)) @(negedge clock);
      end
   end

   // Check every accepted digest beat
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready)
            sb.check_word(rsp_tdata, rsp_tuser, rsp_tlast);
      end
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = 8'h00;
      req_tuser = CMD_ABSORB;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Empty messages, with the ignored data byte at both extremes
      send_beat(CMD_FINISH, 8'hff);
      send_beat(CMD_FINISH, 8'h00);
      // Single-byte extremes
      send_beat(CMD_ABSORB, 8'h00);
      send_beat(CMD_FINISH, 8'ha5);
      send_beat(CMD_ABSORB, 8'hff);
      send_beat(CMD_FINISH, 8'h5a);
      // The classic three-byte vector
      send_beat(CMD_ABSORB, 8'h61);
      send_beat(CMD_ABSORB, 8'h62);
      send_beat(CMD_ABSORB, 8'h63);
      send_beat(CMD_FINISH, 8'h00);

      // Random messages, now and then a stray finish
      while (beats_sent < 430) begin
         if (beats_sent >= 340) quiet = 1'b1;
         if ($urandom_range(0, 9) == 0) send_beat(CMD_FINISH, 8'($urandom_range(0, 255)));
         else send_message(pick_length());
      end
      req_tvalid <= 1'b0;

      // Drain the digest words still owed
      while (sb.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
